[rtl/pfdt_pkg.sv]
// Shared types and constants of the pressure frame depth tracker.
// Frame markers, status codes, register map and arithmetic widths.
// No dependencies.
package pfdt_pkg;

  // frame markers
  localparam logic [7:0] HEAD0_BYTE = 8'hEB;
  localparam logic [7:0] HEAD1_BYTE = 8'h90;
  localparam logic [7:0] TAIL0_BYTE = 8'h0D;
  localparam logic [7:0] TAIL1_BYTE = 8'h0A;

  // register reset values
  localparam logic [15:0]        RST_FIXED_BASELINE = 16'd1026;
  localparam logic [15:0]        RST_PRESS_LIMIT    = 16'd10000;
  localparam logic signed [15:0] RST_TEMP_LIMIT     = 16'sd4199;
  localparam logic [15:0]        RST_DEPTH_GAIN     = 16'd4096;
  localparam logic [15:0]        RST_SMOOTH_K       = 16'd32768;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // serial multiplier: signed A times unsigned B, one B bit per cycle
  localparam int MUL_A_W   = 26;
  localparam int MUL_B_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = 5;

  // speed accumulation
  localparam int SUM_W = MUL_P_W + 1;
  localparam int SPD_W = 25;

  // calibration sum and its serial divider
  localparam int CAL_SUM_W = 19;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_BAD      = 2'd1,
    ST_STOPPED  = 2'd2,
    ST_CAL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CAL_MODE       = 3'd0,
    REG_FIXED_BASELINE = 3'd1,
    REG_PRESS_LIMIT    = 3'd2,
    REG_TEMP_LIMIT     = 3'd3,
    REG_DEPTH_GAIN     = 3'd4,
    REG_SMOOTH_K       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               cal_mode;
    logic [15:0]        fixed_baseline;
    logic [15:0]        press_limit;
    logic signed [15:0] temp_limit;
    logic [15:0]        depth_gain;
    logic [15:0]        smooth_k;
  } cfg_regs_t;

endpackage

[rtl/pfdt_cfg.sv]
// Configuration register file behind an APB-style port.
// Depends on pfdt_pkg for the register map and reset values.
module pfdt_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfdt_pkg::CFG_AW-1:0] paddr,
  input  logic [pfdt_pkg::CFG_DW-1:0] pwdata,
  output logic [pfdt_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output pfdt_pkg::cfg_regs_t         regs
);
  import pfdt_pkg::*;

  cfg_regs_t regs_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.cal_mode       <= 1'b0;
      regs_r.fixed_baseline <= RST_FIXED_BASELINE;
      regs_r.press_limit    <= RST_PRESS_LIMIT;
      regs_r.temp_limit     <= RST_TEMP_LIMIT;
      regs_r.depth_gain     <= RST_DEPTH_GAIN;
      regs_r.smooth_k       <= RST_SMOOTH_K;
    end else if (wr_en) begin
      case (idx)
        REG_CAL_MODE:       regs_r.cal_mode       <= pwdata[0];
        REG_FIXED_BASELINE: regs_r.fixed_baseline <= pwdata[15:0];
        REG_PRESS_LIMIT:    regs_r.press_limit    <= pwdata[15:0];
        REG_TEMP_LIMIT:     regs_r.temp_limit     <= $signed(pwdata[15:0]);
        REG_DEPTH_GAIN:     regs_r.depth_gain     <= pwdata[15:0];
        REG_SMOOTH_K:       regs_r.smooth_k       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAL_MODE:       prdata = {{(CFG_DW-1){1'b0}}, regs_r.cal_mode};
      REG_FIXED_BASELINE: prdata = {16'd0, regs_r.fixed_baseline};
      REG_PRESS_LIMIT:    prdata = {16'd0, regs_r.press_limit};
      REG_TEMP_LIMIT:     prdata = {{16{regs_r.temp_limit[15]}}, regs_r.temp_limit};
      REG_DEPTH_GAIN:     prdata = {16'd0, regs_r.depth_gain};
      REG_SMOOTH_K:       prdata = {16'd0, regs_r.smooth_k};
      default:            prdata = '0;
    endcase
  end

endmodule

[rtl/pfdt_mul.sv]
// Bit-serial shift-add multiplier: signed A times unsigned B, one B bit a cycle.
// Depends on pfdt_pkg for operand and product widths.
module pfdt_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [pfdt_pkg::MUL_A_W-1:0] a,
  input  logic [pfdt_pkg::MUL_B_W-1:0]        b,
  output logic                              done,
  output logic signed [pfdt_pkg::MUL_P_W-1:0] prod
);
  import pfdt_pkg::*;

  logic                      busy_r;
  logic                      done_r;
  logic [MUL_CNT_W-1:0]      cnt_r;
  logic signed [MUL_P_W-1:0] acc_r;
  logic signed [MUL_P_W-1:0] a_sh_r;
  logic [MUL_B_W-1:0]        b_sh_r;

  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == MUL_CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == MUL_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= MUL_CNT_W'(MUL_B_W);
      acc_r  <= '0;
      a_sh_r <= {{(MUL_P_W-MUL_A_W){a[MUL_A_W-1]}}, a};
      b_sh_r <= b;
    end else if (busy_r) begin
      // add the shifted multiplicand for each set multiplier bit
      if (b_sh_r[0]) acc_r <= acc_r + a_sh_r;
      a_sh_r <= a_sh_r <<< 1;
      b_sh_r <= b_sh_r >> 1;
      cnt_r  <= cnt_r - MUL_CNT_W'(1);
    end
  end

endmodule

[rtl/pressure_frame_depth_tracker.sv]
// Pressure frame depth tracker: top level with the frame sequencer.
// Depends on pfdt_pkg, pfdt_cfg and pfdt_mul.
//
// One decoded sensor frame is taken per request and answered with one result.
// The block works on one frame at a time and holds in_stall high while busy.
// A bad, stopped or calibrating frame goes from the check step straight to the
// output step; the frame that completes calibration adds a bit-serial divide by
// CAL_FRAMES; an updating frame runs three products in turn through the single
// bit-serial multiplier, which makes an updating frame the slowest. The result
// sits in an output register, so a waiting result does not block the next
// frame's processing until that frame is ready to be delivered.
module pressure_frame_depth_tracker #(
  parameter int FRAME_LEN  = 13,
  parameter int CAL_FRAMES = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_frame_len,
  input  logic [7:0]                  in_head0,
  input  logic [7:0]                  in_head1,
  input  logic [7:0]                  in_tail0,
  input  logic [7:0]                  in_tail1,
  input  logic [15:0]                 in_pressure_raw,
  input  logic signed [15:0]          in_temp_raw,
  input  logic [15:0]                 in_depth_raw,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [15:0]                 out_pressure,
  output logic signed [15:0]          out_temperature,
  output logic [15:0]                 out_depth_reported,
  output logic [15:0]                 out_calc_depth,
  output logic signed [24:0]          out_speed,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfdt_pkg::CFG_AW-1:0] paddr,
  input  logic [pfdt_pkg::CFG_DW-1:0] pwdata,
  output logic [pfdt_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import pfdt_pkg::*;

  localparam logic [7:0] FLEN_MIN = 8'(FRAME_LEN);
  localparam logic [2:0] CAL_N    = 3'(CAL_FRAMES);
  localparam logic [3:0] CAL_DIV  = 4'(CAL_FRAMES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MUL_DEP,
    S_MUL_DIFF,
    S_MUL_SPD,
    S_EMIT
  } state_t;

  cfg_regs_t regs;

  // sequencer and captured request
  state_t             state_r;
  logic [7:0]         flen_r, h0_r, h1_r, t0_r, t1_r;
  logic [15:0]        praw_r, draw_r;
  logic signed [15:0] temp_r;

  // tracker state
  logic [15:0]              last_good_r;
  logic                     stop_r;
  logic [15:0]              prev_depth_r;
  logic signed [SPD_W-1:0]  prev_speed_r;
  logic [2:0]               cal_count_r;
  logic [CAL_SUM_W-1:0]     cal_sum_r;
  logic [15:0]              cal_base_r;

  // working registers
  logic [15:0]               p_r;
  logic [15:0]               depth_r;
  logic signed [MUL_P_W-1:0] diff_prod_r;
  logic [2:0]                div_rem_r;
  logic [CAL_SUM_W-1:0]      div_quo_r;
  logic [DIV_CNT_W-1:0]      div_cnt_r;

  // multiplier handoff
  logic                      mul_start_r;
  logic                      mul_start_nxt;
  logic signed [MUL_A_W-1:0] mul_a_r;
  logic [MUL_B_W-1:0]        mul_b_r;
  logic                      mul_done;
  logic signed [MUL_P_W-1:0] mul_prod;

  // result staging and output register
  status_t                 res_status_r;
  logic [15:0]             res_press_r, res_draw_r, res_depth_r;
  logic signed [15:0]      res_temp_r;
  logic signed [SPD_W-1:0] res_speed_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [15:0]             out_press_r, out_draw_r, out_depth_r;
  logic signed [15:0]      out_temp_r;
  logic signed [SPD_W-1:0] out_speed_r;

  // combinational helpers
  logic                      frame_ok, cal_active, over_temp;
  logic                      emit_go;
  logic [CAL_SUM_W-1:0]      cal_sum_add;
  logic [2:0]                cal_cnt_inc;
  logic [15:0]               p_sel, base_sel;
  logic signed [16:0]        dep_diff;
  logic [15:0]               depth_sat;
  logic signed [SUM_W-1:0]   spd_sum;
  logic signed [SUM_W-17:0]  spd_full;
  logic signed [SPD_W-1:0]   spd_sat;
  logic [3:0]                div_try;
  logic                      div_ge;
  logic [CAL_SUM_W-1:0]      div_quo_nxt;

  pfdt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  pfdt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    frame_ok = (flen_r >= FLEN_MIN) && (h0_r == HEAD0_BYTE) && (h1_r == HEAD1_BYTE)
               && (t0_r == TAIL0_BYTE) && (t1_r == TAIL1_BYTE);
    cal_active  = regs.cal_mode && (cal_count_r < CAL_N);
    cal_sum_add = cal_sum_r + CAL_SUM_W'(praw_r);
    cal_cnt_inc = cal_count_r + 3'd1;
    over_temp   = temp_r > regs.temp_limit;
    p_sel       = (praw_r < regs.press_limit) ? praw_r : last_good_r;
    base_sel    = regs.cal_mode ? cal_base_r : regs.fixed_baseline;
    emit_go     = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

    // start a product from the check step and after each finished product but the last
    mul_start_nxt = ((state_r == S_CHECK) && frame_ok && !cal_active && !stop_r
                     && !over_temp)
                    || ((state_r inside {S_MUL_DEP, S_MUL_DIFF}) && mul_done);

    // depth = product >> 12, saturated to 16 bits
    depth_sat = (|mul_prod[MUL_P_W-1:28]) ? 16'hFFFF : mul_prod[27:12];
    dep_diff  = $signed({1'b0, depth_sat}) - $signed({1'b0, prev_depth_r});

    // speed: diff*256*(1-k) + prev*k, round half up, floor shift by 16
    spd_sum  = ({diff_prod_r[MUL_P_W-1], diff_prod_r} <<< 8)
               + {mul_prod[MUL_P_W-1], mul_prod} + SUM_W'(32768);
    spd_full = spd_sum[SUM_W-1:16];
    if (spd_full[SUM_W-17:SPD_W-1] == {(SUM_W-16-SPD_W+1){spd_full[SPD_W-1]}}) begin
      spd_sat = spd_full[SPD_W-1:0];
    end else if (spd_full[SUM_W-17]) begin
      spd_sat = {1'b1, {(SPD_W-1){1'b0}}};
    end else begin
      spd_sat = {1'b0, {(SPD_W-1){1'b1}}};
    end

    // restoring divide by CAL_FRAMES, one quotient bit a cycle
    div_try     = {div_rem_r, div_quo_r[CAL_SUM_W-1]};
    div_ge      = div_try >= CAL_DIV;
    div_quo_nxt = {div_quo_r[CAL_SUM_W-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_good_r  <= '0;
      stop_r       <= 1'b0;
      prev_depth_r <= '0;
      prev_speed_r <= '0;
      cal_count_r  <= '0;
      cal_sum_r    <= '0;
      cal_base_r   <= '0;
      mul_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      mul_start_r <= mul_start_nxt;
      out_valid_r <= emit_go | (out_valid_r & out_stall);

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            flen_r  <= in_frame_len;
            h0_r    <= in_head0;
            h1_r    <= in_head1;
            t0_r    <= in_tail0;
            t1_r    <= in_tail1;
            praw_r  <= in_pressure_raw;
            temp_r  <= in_temp_raw;
            draw_r  <= in_depth_raw;
            state_r <= S_CHECK;
          end
        end

        S_CHECK: begin
          // default answer for every frame that does not update
          res_press_r <= last_good_r;
          res_temp_r  <= '0;
          res_draw_r  <= '0;
          res_depth_r <= prev_depth_r;
          res_speed_r <= prev_speed_r;
          if (!frame_ok) begin
            res_status_r <= ST_BAD;
            state_r      <= S_EMIT;
          end else if (cal_active) begin
            res_status_r <= ST_CAL;
            cal_sum_r    <= cal_sum_add;
            cal_count_r  <= cal_cnt_inc;
            if (cal_cnt_inc >= CAL_N) begin
              div_quo_r <= cal_sum_add;
              div_rem_r <= '0;
              div_cnt_r <= DIV_CNT_W'(CAL_SUM_W);
              state_r   <= S_DIV;
            end else begin
              state_r <= S_EMIT;
            end
          end else if (stop_r || over_temp) begin
            stop_r       <= 1'b1;
            res_status_r <= ST_STOPPED;
            state_r      <= S_EMIT;
          end else begin
            res_status_r <= ST_UPDATED;
            p_r          <= p_sel;
            if (praw_r < regs.press_limit) last_good_r <= praw_r;
            mul_a_r      <= (p_sel > base_sel) ? MUL_A_W'(p_sel - base_sel) : '0;
            mul_b_r      <= MUL_B_W'(regs.depth_gain);
            state_r      <= S_MUL_DEP;
          end
        end

        S_DIV: begin
          div_rem_r <= div_ge ? 3'(div_try - CAL_DIV) : div_try[2:0];
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(1)) begin
            cal_base_r <= div_quo_nxt[15:0];
            state_r    <= S_EMIT;
          end
        end

        S_MUL_DEP: begin
          // hold the depth, then issue diff*(65536-k)
          if (mul_done) begin
            depth_r <= depth_sat;
            mul_a_r <= {{(MUL_A_W-17){dep_diff[16]}}, dep_diff};
            mul_b_r <= MUL_B_W'(17'h10000 - {1'b0, regs.smooth_k});
            state_r <= S_MUL_DIFF;
          end
        end

        S_MUL_DIFF: begin
          // keep diff*(65536-k), then issue prev_speed*k
          if (mul_done) begin
            diff_prod_r <= mul_prod;
            mul_a_r     <= {{(MUL_A_W-SPD_W){prev_speed_r[SPD_W-1]}}, prev_speed_r};
            mul_b_r     <= {1'b0, regs.smooth_k};
            state_r     <= S_MUL_SPD;
          end
        end

        S_MUL_SPD: begin
          if (mul_done) begin
            prev_depth_r <= depth_r;
            prev_speed_r <= spd_sat;
            res_press_r  <= p_r;
            res_temp_r   <= temp_r;
            res_draw_r   <= draw_r;
            res_depth_r  <= depth_r;
            res_speed_r  <= spd_sat;
            state_r      <= S_EMIT;
          end
        end

        S_EMIT: begin
          // hold until the output register is free
          if (emit_go) begin
            out_status_r <= res_status_r;
            out_press_r  <= res_press_r;
            out_temp_r   <= res_temp_r;
            out_draw_r   <= res_draw_r;
            out_depth_r  <= res_depth_r;
            out_speed_r  <= res_speed_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_pressure       = out_press_r;
  assign out_temperature    = out_temp_r;
  assign out_depth_reported = out_draw_r;
  assign out_calc_depth     = out_depth_r;
  assign out_speed          = out_speed_r;

endmodule

[bench/pfdt_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the pressure frame depth tracker: mirrors the register file,
// predicts each result from the accepted frame and compares it in order.
// Depends on pfdt_pkg for status codes, register indexes and frame markers.
module pfdt_checker #(
  parameter int FRAME_LEN  = 13,
  parameter int CAL_FRAMES = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  in_frame_len,
  input  logic [7:0]                  in_head0,
  input  logic [7:0]                  in_head1,
  input  logic [7:0]                  in_tail0,
  input  logic [7:0]                  in_tail1,
  input  logic [15:0]                 in_pressure_raw,
  input  logic signed [15:0]          in_temp_raw,
  input  logic [15:0]                 in_depth_raw,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  out_status,
  input  logic [15:0]                 out_pressure,
  input  logic signed [15:0]          out_temperature,
  input  logic [15:0]                 out_depth_reported,
  input  logic [15:0]                 out_calc_depth,
  input  logic signed [24:0]          out_speed,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfdt_pkg::CFG_AW-1:0] paddr,
  input  logic [pfdt_pkg::CFG_DW-1:0] pwdata,
  input  logic                        pready,
  output int                          pending_cnt,
  output int                          err_cnt
);
  import pfdt_pkg::*;

  localparam longint SPEED_MAX = 64'sd16777215;
  localparam longint SPEED_MIN = -64'sd16777216;

  typedef struct packed {
    status_t            status;
    logic [15:0]        pressure;
    logic signed [15:0] temperature;
    logic [15:0]        depth_reported;
    logic [15:0]        calc_depth;
    logic signed [24:0] speed;
  } depth_result_t;

  cfg_regs_t          cfg;
  logic [15:0]        last_good_p;
  logic               stopped;
  logic [15:0]        prev_depth;
  logic signed [24:0] prev_speed;
  logic [2:0]         cal_cnt;
  logic [18:0]        cal_acc;
  logic [15:0]        cal_base;

  depth_result_t depth_results_q[$];
  depth_result_t want;

  initial err_cnt = 0;

  task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, exp_val);
    err_cnt++;
  endtask

  task automatic check_field(input string what, input longint got, input longint exp_val);
    if (got != exp_val) flag_mismatch(what, got, exp_val);
  endtask

  // Advance the tracker state by one frame and return the result it answers with.
  function automatic depth_result_t track_frame(
    input logic [7:0] len, input logic [7:0] h0, input logic [7:0] h1,
    input logic [7:0] t0, input logic [7:0] t1, input logic [15:0] praw,
    input logic signed [15:0] temp, input logic [15:0] draw);
    depth_result_t r;
    logic          good;
    logic [15:0]   p;
    logic [15:0]   base;
    longint        dep;
    longint        acc;
    longint        spd;
    good = (len >= FRAME_LEN) && (h0 == HEAD0_BYTE) && (h1 == HEAD1_BYTE) &&
           (t0 == TAIL0_BYTE) && (t1 == TAIL1_BYTE);
    r.pressure       = last_good_p;
    r.temperature    = '0;
    r.depth_reported = '0;
    r.calc_depth     = prev_depth;
    r.speed          = prev_speed;
    if (!good) begin
      r.status = ST_BAD;
    end else if (cfg.cal_mode && cal_cnt < CAL_FRAMES) begin
      cal_acc = cal_acc + praw;
      cal_cnt = cal_cnt + 3'd1;
      if (cal_cnt >= CAL_FRAMES) cal_base = 16'(cal_acc / CAL_FRAMES);
      r.status = ST_CAL;
    end else begin
      if (temp > $signed(cfg.temp_limit)) stopped = 1'b1;
      if (stopped) begin
        r.status = ST_STOPPED;
      end else begin
        if (praw < cfg.press_limit) begin
          p = praw;
          last_good_p = praw;
        end else begin
          p = last_good_p;
        end
        base = cfg.cal_mode ? cal_base : cfg.fixed_baseline;
        dep = (p > base) ? ((longint'(p - base) * longint'(cfg.depth_gain)) >>> 12) : 0;
        if (dep > 65535) dep = 65535;
        // weighted blend of the new depth step and the old speed, rounded half up
        acc = (dep - longint'(prev_depth)) * 256 * (65536 - longint'(cfg.smooth_k)) +
              longint'(prev_speed) * longint'(cfg.smooth_k) + 32768;
        spd = acc >>> 16;
        if (spd > SPEED_MAX) spd = SPEED_MAX;
        if (spd < SPEED_MIN) spd = SPEED_MIN;
        prev_depth = dep[15:0];
        prev_speed = spd[24:0];
        r.status         = ST_UPDATED;
        r.pressure       = p;
        r.temperature    = temp;
        r.depth_reported = draw;
        r.calc_depth     = prev_depth;
        r.speed          = prev_speed;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg.cal_mode       = 1'b0;
      cfg.fixed_baseline = RST_FIXED_BASELINE;
      cfg.press_limit    = RST_PRESS_LIMIT;
      cfg.temp_limit     = RST_TEMP_LIMIT;
      cfg.depth_gain     = RST_DEPTH_GAIN;
      cfg.smooth_k       = RST_SMOOTH_K;
      last_good_p = '0;
      stopped     = 1'b0;
      prev_depth  = '0;
      prev_speed  = '0;
      cal_cnt     = '0;
      cal_acc     = '0;
      cal_base    = '0;
      depth_results_q.delete();
      pending_cnt <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_AW-1:2]))
          REG_CAL_MODE:       cfg.cal_mode       = pwdata[0];
          REG_FIXED_BASELINE: cfg.fixed_baseline = pwdata[15:0];
          REG_PRESS_LIMIT:    cfg.press_limit    = pwdata[15:0];
          REG_TEMP_LIMIT:     cfg.temp_limit     = pwdata[15:0];
          REG_DEPTH_GAIN:     cfg.depth_gain     = pwdata[15:0];
          REG_SMOOTH_K:       cfg.smooth_k       = pwdata[15:0];
          default: ;
        endcase
      end
      // retire results before taking new requests: a fresh request cannot answer this edge
      if (out_valid && !out_stall) begin
        if (depth_results_q.size() == 0) begin
          flag_mismatch("result with no request pending, status", out_status, -1);
        end else begin
          want = depth_results_q.pop_front();
          check_field("status", out_status, want.status);
          check_field("pressure", out_pressure, want.pressure);
          check_field("temperature", out_temperature, want.temperature);
          check_field("depth_reported", out_depth_reported, want.depth_reported);
          check_field("calc_depth", out_calc_depth, want.calc_depth);
          check_field("speed", out_speed, want.speed);
        end
      end
      if (in_valid && !in_stall)
        depth_results_q.push_back(track_frame(in_frame_len, in_head0, in_head1, in_tail0,
                                              in_tail1, in_pressure_raw, in_temp_raw,
                                              in_depth_raw));
      pending_cnt <= depth_results_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Top of the pressure frame depth tracker bench: clock, reset, frame and
// register stimulus, result-side stalls and the verdict.
// Depends on pfdt_pkg, pressure_frame_depth_tracker and pfdt_checker.
module tb_top;
  import pfdt_pkg::*;

  localparam int MIN_LEN = 13;

  typedef struct {
    logic [7:0]         len;
    logic [7:0]         h0;
    logic [7:0]         h1;
    logic [7:0]         t0;
    logic [7:0]         t1;
    logic [15:0]        praw;
    logic signed [15:0] temp;
    logic [15:0]        draw;
  } frame_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          in_frame_len;
  logic [7:0]          in_head0;
  logic [7:0]          in_head1;
  logic [7:0]          in_tail0;
  logic [7:0]          in_tail1;
  logic [15:0]         in_pressure_raw;
  logic signed [15:0]  in_temp_raw;
  logic [15:0]         in_depth_raw;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_status;
  logic [15:0]         out_pressure;
  logic signed [15:0]  out_temperature;
  logic [15:0]         out_depth_reported;
  logic [15:0]         out_calc_depth;
  logic signed [24:0]  out_speed;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  int                  pending_cnt;
  int                  err_cnt;

  logic                quiet;
  logic                hold_go;
  bit                  hold_done;
  logic [15:0]         cur_plim;
  logic signed [15:0]  cur_tlim;

  pressure_frame_depth_tracker u_top (.*);
  pfdt_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 6);
      end
    end
  end

  function automatic frame_t mk(input logic [15:0] p, input logic signed [15:0] t,
                                input logic [15:0] d);
    frame_t f;
    f.len  = 8'(MIN_LEN);
    f.h0   = HEAD0_BYTE;
    f.h1   = HEAD1_BYTE;
    f.t0   = TAIL0_BYTE;
    f.t1   = TAIL1_BYTE;
    f.praw = p;
    f.temp = t;
    f.draw = d;
    return f;
  endfunction

  // Mostly well-formed frames; hot_pct of them run over the temperature limit.
  function automatic frame_t rand_frame(input int hot_pct);
    frame_t f;
    int     lo;
    int     hi;
    int     t;
    f = mk(16'($urandom), 16'sd0, 16'($urandom));
    f.len = 8'($urandom_range(MIN_LEN, 255));
    case ($urandom_range(0, 3))
      0: f.praw = 16'($urandom_range(0, 4095));
      1: f.praw = cur_plim + 16'($urandom_range(0, 2)) - 16'd1;
      default: ;
    endcase
    if (cur_tlim < 32767 && $urandom_range(0, 99) < hot_pct) begin
      lo = cur_tlim + 1;
      hi = 32767;
    end else begin
      lo = -32768;
      hi = cur_tlim;
    end
    t = lo + int'($urandom_range(0, hi - lo));
    f.temp = 16'(t);
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 4))
        0: f.len = 8'($urandom_range(0, MIN_LEN - 1));
        1: f.h0 = 8'($urandom_range(0, 255)) ^ (f.h0 == HEAD0_BYTE ? 8'h00 : 8'h00) ^ 8'h01;
        2: f.h1 = 8'($urandom_range(0, 255)) | 8'h01;
        3: f.t0 = 8'($urandom_range(0, 255)) | 8'h10;
        default: f.t1 = 8'($urandom_range(0, 255)) | 8'h01;
      endcase
      // a random marker can still land on the right value; knock it off
      if (f.h0 == HEAD0_BYTE && f.h1 == HEAD1_BYTE && f.t0 == TAIL0_BYTE &&
          f.t1 == TAIL1_BYTE && f.len >= MIN_LEN) f.h0 = ~HEAD0_BYTE;
    end
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_frame_len    <= f.len;
    in_head0        <= f.h0;
    in_head1        <= f.h1;
    in_tail0        <= f.t0;
    in_tail1        <= f.t1;
    in_pressure_raw <= f.praw;
    in_temp_raw     <= f.temp;
    in_depth_raw    <= f.draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every request has been answered.
  task automatic settle;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic run_frames(input int n, input int hot_pct);
    repeat (n) send_frame(rand_frame(hot_pct));
    settle();
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic cal, input logic [15:0] base, input logic [15:0] plim,
                            input logic signed [15:0] tlim, input logic [15:0] gain,
                            input logic [15:0] k);
    write_reg(REG_CAL_MODE, {15'd0, cal});
    write_reg(REG_FIXED_BASELINE, base);
    write_reg(REG_PRESS_LIMIT, plim);
    write_reg(REG_TEMP_LIMIT, tlim);
    write_reg(REG_DEPTH_GAIN, gain);
    write_reg(REG_SMOOTH_K, k);
    cur_plim = plim;
    cur_tlim = tlim;
  endtask

  initial begin
    frame_t fr;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_frame_len    <= '0;
    in_head0        <= '0;
    in_head1        <= '0;
    in_tail0        <= '0;
    in_tail1        <= '0;
    in_pressure_raw <= '0;
    in_temp_raw     <= '0;
    in_depth_raw    <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    quiet           <= 1'b0;
    hold_go         <= 1'b0;
    cur_plim = RST_PRESS_LIMIT;
    cur_tlim = RST_TEMP_LIMIT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: limits, baseline edges and every broken marker
    send_frame(mk(16'd2000, 16'sd2500, 16'd1234));
    send_frame(mk(16'd0, -16'sd32768, 16'd0));
    send_frame(mk(16'd1026, 16'sd4199, 16'hFFFF));
    send_frame(mk(16'd1027, 16'sd100, 16'd1));
    send_frame(mk(16'd9999, -16'sd1, 16'd5));
    send_frame(mk(16'd10000, 16'sd0, 16'd6));
    send_frame(mk(16'hFFFF, 16'sd0, 16'd7));
    fr = mk(16'd3000, 16'sd0, 16'd8);
    fr.len = 8'd12;  send_frame(fr);
    fr.len = 8'd0;   send_frame(fr);
    fr.len = 8'd255; send_frame(fr);
    fr = mk(16'd3000, 16'sd0, 16'd8); fr.h0 = 8'h00; send_frame(fr);
    fr = mk(16'd3000, 16'sd0, 16'd8); fr.h1 = 8'hFF; send_frame(fr);
    fr = mk(16'd3000, 16'sd0, 16'd8); fr.t0 = TAIL1_BYTE; send_frame(fr);
    fr = mk(16'd3000, 16'sd0, 16'd8); fr.t1 = TAIL0_BYTE; send_frame(fr);
    settle();

    // full gain, no smoothing: saturated depth, then a full-scale drop
    set_config(1'b0, 16'd0, 16'hFFFF, 16'sd32767, 16'hFFFF, 16'd0);
    send_frame(mk(16'd65534, 16'sd32767, 16'd0));
    send_frame(mk(16'd0, 16'sd0, 16'd0));
    send_frame(mk(16'hFFFF, 16'sd0, 16'd0));
    send_frame(mk(16'd40000, 16'sd0, 16'd0));
    settle();

    set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'sd32767, 16'd0, 16'hFFFF);
    send_frame(mk(16'd65534, 16'sd0, 16'd0));
    send_frame(mk(16'd100, 16'sd0, 16'd0));
    settle();

    // start calibration, leave it half done across a mode change, then finish it
    set_config(1'b1, 16'd500, 16'd60000, 16'sd32767, 16'd4096, 16'd32768);
    send_frame(mk(16'd20000, 16'sd0, 16'd0));
    fr = mk(16'd1, 16'sd0, 16'd0); fr.h1 = 8'h00; send_frame(fr);
    send_frame(mk(16'd21000, 16'sd0, 16'd0));
    send_frame(mk(16'hFFFF, 16'sd0, 16'd0));
    settle();
    set_config(1'b0, 16'd800, 16'd50000, 16'sd32767, 16'd6000, 16'd20000);
    run_frames(120, 0);
    set_config(1'b1, 16'd800, 16'd50000, 16'sd32767, 16'd6000, 16'd20000);
    hold_go <= 1'b1;
    run_frames(150, 0);

    for (int i = 0; i < 4; i++) begin
      quiet <= (i == 2);
      set_config(1'($urandom_range(0, 1)), 16'($urandom_range(0, 3000)),
                 (i == 1) ? 16'd0 : (i == 3) ? 16'hFFFF : 16'($urandom_range(1000, 65535)),
                 16'sd32767, 16'($urandom), 16'($urandom));
      run_frames(130, 0);
    end
    quiet <= 1'b0;

    // latch the stop with a mid-range limit, then the lowest limit
    set_config(1'b0, 16'd1026, 16'd10000, 16'sd1000, 16'd4096, 16'd32768);
    run_frames(60, 4);
    set_config(1'b1, 16'd1026, 16'd10000, -16'sd32768, 16'd4096, 16'd32768);
    run_frames(40, 50);

    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pfdt_pkg.sv
rtl/pfdt_cfg.sv
rtl/pfdt_mul.sv
rtl/pressure_frame_depth_tracker.sv
bench/pfdt_checker.sv
bench/tb_top.sv
